// File: hw/rtl/affine_motion_smoother_core_assert.svh
// Assertion macros used by the affine motion smoother RTL.
`ifndef AFFINE_MOTION_SMOOTHER_CORE_ASSERT_SVH
`define AFFINE_MOTION_SMOOTHER_CORE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define AMSC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AMSC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define AMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/amsm_pkg.sv
// Shared constants and types of the affine motion smoother.
package amsm_pkg;

    localparam int WINDOW_DEF    = 24;
    localparam int COEF_BITS_DEF = 32;
    localparam int NCOEF         = 6;
    localparam int K_W           = $clog2(NCOEF);
    localparam int FRAC_BITS     = 16;
    localparam int IDX_SX        = 2;
    localparam int IDX_SY        = 5;

    localparam int LIMIT_W    = 8;
    localparam int DEADBAND_W = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0]    X_LIMIT_RST  = 8'd5;
    localparam logic [LIMIT_W-1:0]    Y_LIMIT_RST  = 8'd20;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 16'd6554;

    typedef enum logic [1:0] {
        CFG_REAR_MODE = 2'd0,
        CFG_X_LIMIT   = 2'd1,
        CFG_Y_LIMIT   = 2'd2,
        CFG_DEADBAND  = 2'd3
    } cfg_index_t;

endpackage

// File: hw/rtl/amsm_ram.sv
// Generic single-port RAM with registered read data.
module amsm_ram #(
    parameter int WIDTH = amsm_pkg::COEF_BITS_DEF,
    parameter int DEPTH = amsm_pkg::WINDOW_DEF * amsm_pkg::NCOEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/amsm_div.sv
// Bit-serial restoring divider: signed sum over unsigned entry count.
module amsm_div #(
    parameter int COEF_BITS = amsm_pkg::COEF_BITS_DEF,
    parameter int SUM_W     = amsm_pkg::COEF_BITS_DEF + $clog2(amsm_pkg::WINDOW_DEF),
    parameter int CNT_W     = $clog2(amsm_pkg::WINDOW_DEF + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_W-1:0]     dividend,
    input  logic [CNT_W-1:0]            divisor,
    output logic                        done,
    output logic signed [COEF_BITS-1:0] quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic [CNT_W:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]     q_reg, q_next;
    logic [COEF_BITS-1:0] quot_reg, quot_next;

    logic [CNT_W:0]   shifted;
    logic [CNT_W+1:0] diff;
    logic [SUM_W-1:0] dividend_mag;
    logic [SUM_W-1:0] q_signed;

    always_comb
    begin
        shifted      = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        diff         = {1'b0, shifted} - {2'b00, divisor};
        dividend_mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
        q_signed     = neg_reg ? (~q_reg + SUM_W'(1)) : q_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_W-1];
            iter_next = ITER_W'(SUM_W);
            rem_next  = '0;
            q_next    = dividend_mag;
        end
        else if (busy_reg && (iter_reg != '0))
        begin
            // one quotient bit per cycle
            iter_next = iter_reg - ITER_W'(1);
            if (!diff[CNT_W+1])
            begin
                rem_next = diff[CNT_W:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
        end
        else if (busy_reg)
        begin
            // restore sign, truncation toward zero falls out of magnitude division
            quot_next = q_signed[COEF_BITS-1:0];
            done_next = 1'b1;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: hw/rtl/affine_motion_smoother_core.sv
// Affine motion smoother top level: outlier rejection, windowed mean, rear adjust.
//
//  channel   direction  handshake                     payload
//  ---------------------------------------------------------------------------
//  item      in         item_valid / item_stall       coef_a coef_b shift_x
//                                                     coef_c coef_d shift_y
//  result    out        result_valid / result_stall   avg_a avg_b avg_shift_x
//                                                     avg_c avg_d avg_shift_y rejected
//  cfg       in         cfg_we (no wait)              cfg_index cfg_data
//
//  The bit-serial divider runs once per coefficient in every transaction.
//  item_stall is high from acceptance until the result reaches the output register, so the
//  next item may be taken while that result still waits; a stalled result holds the
//  sequencer in its final step. Reset clears sums, fill count, ring slot, last output and
//  config; the history RAM is not cleared, its read data counts only once the ring is full.
module affine_motion_smoother_core #(
    parameter int WINDOW    = amsm_pkg::WINDOW_DEF,
    parameter int COEF_BITS = amsm_pkg::COEF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [COEF_BITS-1:0]       coef_a,
    input  logic signed [COEF_BITS-1:0]       coef_b,
    input  logic signed [COEF_BITS-1:0]       shift_x,
    input  logic signed [COEF_BITS-1:0]       coef_c,
    input  logic signed [COEF_BITS-1:0]       coef_d,
    input  logic signed [COEF_BITS-1:0]       shift_y,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [COEF_BITS-1:0]       avg_a,
    output logic signed [COEF_BITS-1:0]       avg_b,
    output logic signed [COEF_BITS-1:0]       avg_shift_x,
    output logic signed [COEF_BITS-1:0]       avg_c,
    output logic signed [COEF_BITS-1:0]       avg_d,
    output logic signed [COEF_BITS-1:0]       avg_shift_y,
    output logic                              rejected,

    input  logic                              cfg_we,
    input  amsm_pkg::cfg_index_t              cfg_index,
    input  logic [amsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import amsm_pkg::*;

`include "affine_motion_smoother_core_assert.svh"

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = COEF_BITS + $clog2(WINDOW);
    localparam int DEPTH  = WINDOW * NCOEF;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [SUM_W-1:0]     sum_t;

    // sequencer: ring update pass, then one divide per coefficient
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD       = 6'b000010,
        ST_UPD      = 6'b000100,
        ST_DIV_GO   = 6'b001000,
        ST_DIV_WAIT = 6'b010000,
        ST_ADJ      = 6'b100000
    } state_t;

    function automatic logic [COEF_BITS-1:0] mag_of(input coef_t v);
        return v[COEF_BITS-1] ? (~v + COEF_BITS'(1)) : v;
    endfunction

    function automatic sum_t widen(input coef_t v);
        return {{(SUM_W-COEF_BITS){v[COEF_BITS-1]}}, v};
    endfunction

    // configuration registers
    logic                  rear_mode_reg;
    logic [LIMIT_W-1:0]    x_limit_reg;
    logic [LIMIT_W-1:0]    y_limit_reg;
    logic [DEADBAND_W-1:0] deadband_reg;

    // control and state
    state_t            state_reg, state_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic              res_valid_reg, res_valid_next;
    sum_t              sum_reg [NCOEF];
    sum_t              sum_next [NCOEF];
    coef_t             res_reg [NCOEF];   // output register, doubles as last output
    coef_t             res_next [NCOEF];

    // payload
    coef_t m_reg [NCOEF];
    coef_t m_next [NCOEF];
    coef_t avg_reg [NCOEF];
    coef_t avg_next [NCOEF];
    logic  rej_pend_reg, rej_pend_next;
    logic  rej_out_reg, rej_out_next;

    coef_t item_coef [NCOEF];
    logic  outlier;
    logic  ring_full;
    logic  k_last;
    logic  out_free;
    logic  small_shift;
    sum_t  evict;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [COEF_BITS-1:0] ram_rdata;

    logic  div_start;
    logic  div_done;
    coef_t div_quot;

    assign item_coef[0] = coef_a;
    assign item_coef[1] = coef_b;
    assign item_coef[2] = shift_x;
    assign item_coef[3] = coef_c;
    assign item_coef[4] = coef_d;
    assign item_coef[5] = shift_y;

    // integer part of the exact magnitude against the limits
    assign outlier = ((mag_of(shift_x) >> FRAC_BITS) > COEF_BITS'(x_limit_reg)) ||
                     ((mag_of(shift_y) >> FRAC_BITS) > COEF_BITS'(y_limit_reg));

    assign ring_full = (fill_cnt_reg == CNT_W'(WINDOW));
    assign k_last    = (k_reg == K_W'(NCOEF - 1));
    assign out_free  = !res_valid_reg || !result_stall;
    assign ram_addr  = ADDR_W'(slot_reg * NCOEF) + ADDR_W'(k_reg);
    assign evict     = ring_full ? widen(coef_t'(ram_rdata)) : '0;

    assign small_shift = (mag_of(avg_reg[IDX_SX]) < COEF_BITS'(deadband_reg)) &&
                         (mag_of(avg_reg[IDX_SY]) < COEF_BITS'(deadband_reg));

    amsm_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (m_reg[k_reg]),
        .rdata (ram_rdata)
    );

    amsm_div #(
        .COEF_BITS (COEF_BITS),
        .SUM_W     (SUM_W),
        .CNT_W     (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[k_reg]),
        .divisor  (fill_cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        fill_cnt_next  = fill_cnt_reg;
        res_valid_next = res_valid_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        m_next         = m_reg;
        avg_next       = avg_reg;
        rej_pend_next  = rej_pend_reg;
        rej_out_next   = rej_out_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        item_stall     = (state_reg != ST_IDLE);

        // drop the held result once the consumer takes it
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    // outliers are replaced by the last output
                    for (int i = 0; i < NCOEF; i++)
                    begin
                        m_next[i] = outlier ? res_reg[i] : item_coef[i];
                    end
                    rej_pend_next = outlier;
                    k_next        = '0;
                    state_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                // history read issued, data arrives next cycle
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ram_we          = 1'b1;
                sum_next[k_reg] = sum_reg[k_reg] - evict + widen(m_reg[k_reg]);
                if (k_last)
                begin
                    k_next     = '0;
                    slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);
                    if (!ring_full)
                    begin
                        fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                    end
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    avg_next[k_reg] = div_quot;
                    if (k_last)
                    begin
                        k_next     = '0;
                        state_next = ST_ADJ;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_ADJ:
            begin
                // hold until the output register is free, then load it
                if (out_free)
                begin
                    res_next = avg_reg;
                    if (rear_mode_reg)
                    begin
                        res_next[IDX_SX] = '0;
                        if (small_shift)
                        begin
                            res_next[IDX_SY] = '0;
                        end
                    end
                    rej_out_next   = rej_pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            slot_reg      <= '0;
            fill_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NCOEF; i++)
            begin
                sum_reg[i] <= '0;
                res_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            slot_reg      <= slot_next;
            fill_cnt_reg  <= fill_cnt_next;
            res_valid_reg <= res_valid_next;
            sum_reg       <= sum_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        avg_reg      <= avg_next;
        rej_pend_reg <= rej_pend_next;
        rej_out_reg  <= rej_out_next;
    end

    // configuration writes, masked to register widths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rear_mode_reg <= 1'b0;
            x_limit_reg   <= X_LIMIT_RST;
            y_limit_reg   <= Y_LIMIT_RST;
            deadband_reg  <= DEADBAND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REAR_MODE: rear_mode_reg <= cfg_data[0];
                CFG_X_LIMIT:   x_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_Y_LIMIT:   y_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_DEADBAND:  deadband_reg  <= cfg_data[DEADBAND_W-1:0];
                default:       rear_mode_reg <= rear_mode_reg;
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign avg_a        = res_reg[0];
    assign avg_b        = res_reg[1];
    assign avg_shift_x  = res_reg[2];
    assign avg_c        = res_reg[3];
    assign avg_d        = res_reg[4];
    assign avg_shift_y  = res_reg[5];
    assign rejected     = rej_out_reg;

    `AMSC_ASSERT_ALWAYS(a_fill_bound, fill_cnt_reg <= CNT_W'(WINDOW), "fill count above window")
    `AMSC_ASSERT_IMPLIES(a_slot_tracks_fill, !ring_full, CNT_W'(slot_reg) == fill_cnt_reg, "ring slot out of step with fill count")
    `AMSC_ASSERT_NEXT(a_accept_starts, item_valid && !item_stall, state_reg == ST_RD, "accepted transaction did not start the ring pass")
    `AMSC_ASSERT_IMPLIES(a_result_has_history, res_valid_reg, fill_cnt_reg != '0, "result shown with empty ring")
    `AMSC_ASSERT_IMPLIES(a_div_done_expected, div_done, state_reg == ST_DIV_WAIT, "divider finished outside its wait step")

endmodule
